### src/sha1md_pkg.sv
`default_nettype none
package sha1md_pkg;

    localparam int HASH_WORDS  = 5;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;
    localparam int COUNT_W     = 61;
    localparam int ROUND_W     = 7;
    localparam int POS_W       = 6;
    localparam int IDX_W       = 3;

    localparam logic [7:0] PAD_FIRST_BYTE = 8'h80;
    localparam logic [IDX_W-1:0] LAST_IDX = 3'd4;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [POS_W-1:0] BLOCK_END_POS = 6'd63;
    localparam logic [POS_W-1:0] PAD_END_POS = 6'd55;

    localparam logic [31:0] INIT_H [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0]      digest_word;
        logic [IDX_W-1:0] word_index;
        logic             last_word;
    } t_out_item;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic               take_byte;
        logic               pad_byte;
        logic [POS_W-1:0]   pad_pos;
        logic               pad_first;
        logic               len_wr;
        logic               load_vars;
        logic               do_round;
        logic [ROUND_W-1:0] round;
        logic               add_chain;
        logic               restart;
        logic [IDX_W-1:0]   out_idx;
    } t_dp_cmd;

    function automatic logic [31:0] round_const(input logic [ROUND_W-1:0] r);
        logic [31:0] k;
        if (r < 7'd20) begin
            k = 32'h5A827999;
        end else if (r < 7'd40) begin
            k = 32'h6ED9EBA1;
        end else if (r < 7'd60) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

    function automatic logic [31:0] round_func(input logic [ROUND_W-1:0] r,
                                               input logic [31:0] b,
                                               input logic [31:0] c,
                                               input logic [31:0] d);
        logic [31:0] f;
        if (r < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (r < 7'd40) begin
            f = b ^ c ^ d;
        end else if (r < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage
`default_nettype wire

### src/sha1md_ctrl.sv
`default_nettype none
module sha1md_ctrl (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire                          i_byte_present,
    input  wire                          i_end_of_message,
    input  wire                          i_out_stall,
    input  wire  [sha1md_pkg::POS_W-1:0] i_cnt_pos,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output sha1md_pkg::t_dp_cmd          o_cmd
);
    import sha1md_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_LEN   = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]         r_state, n_state;
    logic [2:0]         r_ret, n_ret;
    logic [ROUND_W-1:0] r_round, n_round;
    logic [POS_W-1:0]   r_pad, n_pad;
    logic               r_first, n_first;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               accept;

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_round = r_round;
        n_pad   = r_pad;
        n_first = r_first;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.pad_pos   = r_pad;
        o_cmd.pad_first = r_first;
        o_cmd.round     = r_round;
        o_cmd.out_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.take_byte = i_byte_present;
                    n_pad   = i_cnt_pos + POS_W'(i_byte_present);
                    n_first = 1'b1;
                    priority if (i_byte_present && i_cnt_pos == BLOCK_END_POS) begin
                        o_cmd.load_vars = 1'b1;
                        n_round = '0;
                        n_state = S_ROUND;
                        n_ret   = i_end_of_message ? S_PAD : S_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PAD: begin
                o_cmd.pad_byte = 1'b1;
                n_first = 1'b0;
                priority if (r_pad == BLOCK_END_POS) begin
                    o_cmd.load_vars = 1'b1;
                    n_pad   = '0;
                    n_round = '0;
                    n_state = S_ROUND;
                    n_ret   = S_PAD;
                end else if (r_pad == PAD_END_POS) begin
                    n_state = S_LEN;
                end else begin
                    n_pad = r_pad + POS_W'(1);
                end
            end
            S_LEN: begin
                o_cmd.len_wr    = 1'b1;
                o_cmd.load_vars = 1'b1;
                n_round = '0;
                n_idx   = '0;
                n_state = S_ROUND;
                n_ret   = S_OUT;
            end
            S_ROUND: begin
                o_cmd.do_round = 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_round = '0;
                    n_state = S_ADD;
                end else begin
                    n_round = r_round + ROUND_W'(1);
                end
            end
            S_ADD: begin
                o_cmd.add_chain = 1'b1;
                n_state = r_ret;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_idx == LAST_IDX) begin
                        o_cmd.restart = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_round <= '0;
            r_pad   <= '0;
            r_first <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_round <= n_round;
            r_pad   <= n_pad;
            r_first <= n_first;
            r_idx   <= n_idx;
        end
    end

endmodule
`default_nettype wire

### src/sha1md_dp.sv
`default_nettype none
module sha1md_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  sha1md_pkg::t_dp_cmd          i_cmd,
    input  wire  [7:0]                   i_msg_byte,
    output logic [sha1md_pkg::POS_W-1:0] o_cnt_pos,
    output sha1md_pkg::t_out_item        o_out_data
);
    import sha1md_pkg::*;

    logic [31:0]        r_w [BLOCK_WORDS];
    logic [31:0]        r_v [HASH_WORDS];
    logic [31:0]        r_h [HASH_WORDS];
    logic [COUNT_W-1:0] r_cnt;

    logic               wr_en;
    logic [POS_W-1:0]   wr_pos;
    logic [7:0]         wr_byte;
    logic [3:0]         wr_word;
    logic [63:0]        bit_len;
    logic [31:0]        sched_new;
    logic [31:0]        round_t;

    assign o_cnt_pos = r_cnt[POS_W-1:0];

    // one byte write port shared by message bytes and padding bytes
    assign wr_en   = i_cmd.take_byte || i_cmd.pad_byte;
    assign wr_pos  = i_cmd.take_byte ? r_cnt[POS_W-1:0] : i_cmd.pad_pos;
    assign wr_byte = i_cmd.take_byte ? i_msg_byte
                   : (i_cmd.pad_first ? PAD_FIRST_BYTE : 8'h00);
    assign wr_word = wr_pos[POS_W-1:2];
    assign bit_len = {r_cnt, 3'b000};

    assign sched_new = {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]} << 1
                     | (r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]) >> 31;
    assign round_t = {r_v[0][26:0], r_v[0][31:27]}
                   + round_func(i_cmd.round, r_v[1], r_v[2], r_v[3])
                   + r_v[4] + r_w[0] + round_const(i_cmd.round);

    // block words: byte writes while filling, the bit length at the end, a sliding window while compressing
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_round) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BLOCK_WORDS-1] <= sched_new;
        end else if (i_cmd.len_wr) begin
            r_w[BLOCK_WORDS-2] <= bit_len[63:32];
            r_w[BLOCK_WORDS-1] <= bit_len[31:0];
        end else if (wr_en) begin
            unique case (wr_pos[1:0])
                2'd0: r_w[wr_word]        <= {wr_byte, 24'h000000};
                2'd1: r_w[wr_word][23:16] <= wr_byte;
                2'd2: r_w[wr_word][15:8]  <= wr_byte;
                2'd3: r_w[wr_word][7:0]   <= wr_byte;
                default: r_w[wr_word][7:0] <= wr_byte;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vars) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.do_round) begin
            r_v[0] <= round_t;
            r_v[1] <= r_v[0];
            r_v[2] <= {r_v[1][1:0], r_v[1][31:2]};
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_h[i] <= INIT_H[i];
            end
            r_cnt <= '0;
        end else begin
            if (i_cmd.add_chain) begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.take_byte) begin
                r_cnt <= r_cnt + COUNT_W'(1);
            end
        end
    end

    always_comb begin
        o_out_data.digest_word = r_h[0];
        unique case (i_cmd.out_idx)
            3'd0: o_out_data.digest_word = r_h[0];
            3'd1: o_out_data.digest_word = r_h[1];
            3'd2: o_out_data.digest_word = r_h[2];
            3'd3: o_out_data.digest_word = r_h[3];
            3'd4: o_out_data.digest_word = r_h[4];
            default: o_out_data.digest_word = r_h[0];
        endcase
        o_out_data.word_index = i_cmd.out_idx;
        o_out_data.last_word  = (i_cmd.out_idx == LAST_IDX);
    end

endmodule
`default_nettype wire

### src/sha1_message_digest.sv
`default_nettype none
// SHA-1 digest engine, one message byte per transaction.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): each transaction carries
// a byte (used when byte_present is set) and an end_of_message flag. A
// transaction with neither flag set is ignored.
// Output channel (o_out_valid / i_out_stall / o_out_data): five transactions
// per message, H0 through H4, the last flagged with last_word.
//
// Throughput: a byte is taken every cycle while a block fills; the 64th byte
// of a block starts a compression that holds the input through its 80 rounds
// on the single shared round unit and the chaining add.
// Finishing a message pads one byte per cycle up to position 55, writes the
// length and compresses, plus one more pad sweep and compression when fewer
// than 9 block bytes remain. The digest words then stream out in order.
// The input is stalled whenever the engine is not waiting for a byte.
// A stall on the output holds the current digest word and freezes the engine.
// Reset (synchronous, active low) loads the initial hash, clears the length
// and returns to waiting for bytes; after the last digest word the same
// restart happens, ready for the next message.
module sha1_message_digest (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  sha1md_pkg::t_in_item   i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output sha1md_pkg::t_out_item  o_out_data
);
    import sha1md_pkg::*;

    t_dp_cmd          cmd;
    logic [POS_W-1:0] cnt_pos;

    // sequencer: byte intake, padding, round count, digest readout
    sha1md_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_byte_present   (i_in_data.byte_present),
        .i_end_of_message (i_in_data.end_of_message),
        .i_out_stall      (i_out_stall),
        .i_cnt_pos        (cnt_pos),
        .o_in_stall       (o_in_stall),
        .o_out_valid      (o_out_valid),
        .o_cmd            (cmd)
    );

    // datapath: block window, round unit, chaining hash, length counter
    sha1md_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_msg_byte (i_in_data.msg_byte),
        .o_cnt_pos  (cnt_pos),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire

### src/sha1md_chk.sv
`default_nettype none
module sha1md_chk (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_in_valid,
    input wire                   o_in_stall,
    input sha1md_pkg::t_in_item  i_in_data,
    input wire                   o_out_valid,
    input wire                   i_out_stall,
    input sha1md_pkg::t_out_item o_out_data
);
    import sha1md_pkg::*;

    // no input is taken while a digest is being read out
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted during digest readout");

    // digest words come as one burst in order
    a_burst_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last_word) |=>
        (o_out_valid && o_out_data.word_index == $past(o_out_data.word_index) + 3'd1))
        else $error("digest burst broken or out of order");

    // burst ends after the last word
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last_word) |=> !o_out_valid)
        else $error("output valid after last digest word");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output changed");

endmodule

bind sha1_message_digest sha1md_chk u_sha1md_chk (.*);
`default_nettype wire

### bench/sha1_message_digest_test.sv
`timescale 1ns / 1ps

module sha1_message_digest_test;

    import sha1md_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int MAX_WAIT      = 13;
    localparam int RANDOM_ITEMS  = 100;
    localparam int RANDOM_MSGS   = 12;
    localparam int REPORT_LIMIT  = 10;

    localparam bit [159:0] NO_DIGEST    = 160'h0;
    localparam bit [159:0] EMPTY_DIGEST =
        160'hDA39A3EE_5E6B4B0D_3255BFEF_95601890_AFD80709;
    localparam bit [159:0] ABC_DIGEST   =
        160'hA9993E36_4706816A_BA3E2571_7850C26C_9CD0D89D;

    localparam bit [31:0] SHA_IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // One directed transaction; a known digest overrides the prediction.
    typedef struct packed {
        t_in_item   item;
        bit         known;
        bit [159:0] digest;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 16;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        {8'h5A, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // idle transaction
        {8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message
        {8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        {8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        {8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},     // idle inside a message
        {8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},    // last byte rides on the end
        {8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        {8'hFF, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        {8'hFF, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        {8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        {8'h7F, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        {8'h00, 1'b0, 1'b1, 1'b0, NO_DIGEST},     // empty end after bytes
        {8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST},     // one-byte messages
        {8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        {8'hA5, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        {8'h5A, 1'b1, 1'b1, 1'b0, NO_DIGEST}
    };

    logic      clk;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data  = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    // Predictor state: chaining hash, block being filled, byte length.
    bit [31:0] sha_chain [5];
    bit [31:0] sha_block [16];
    bit [60:0] sha_len;

    t_out_item pending_words [$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        stall_left     = 0;
    bit        send_quiet     = 1'b0;
    bit        recv_quiet     = 1'b0;
    int        random_items   = 0;
    int        random_msgs    = 0;

    sha1_message_digest DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void sha_restart();
        for (int i = 0; i < 5; i++) sha_chain[i] = SHA_IV[i];
        for (int i = 0; i < 16; i++) sha_block[i] = '0;
        sha_len = '0;
    endfunction

    function automatic void sha_compress();
        bit [31:0] sched [80];
        bit [31:0] a, b, c, d, e, f, k, t, x;
        for (int i = 0; i < 16; i++) sched[i] = sha_block[i];
        for (int i = 16; i < 80; i++) begin
            x = sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16];
            sched[i] = {x[30:0], x[31]};
        end
        a = sha_chain[0];
        b = sha_chain[1];
        c = sha_chain[2];
        d = sha_chain[3];
        e = sha_chain[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + sched[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        sha_chain[0] += a;
        sha_chain[1] += b;
        sha_chain[2] += c;
        sha_chain[3] += d;
        sha_chain[4] += e;
    endfunction

    // Place a byte big-endian in the block; compress once the block is full.
    function automatic void sha_put_byte(bit [5:0] pos, bit [7:0] val);
        bit [3:0] wi;
        wi = pos[5:2];
        if (pos[1:0] == 2'd0) sha_block[wi] = '0;
        sha_block[wi][(3 - pos[1:0]) * 8 +: 8] = val;
        if (pos == 6'd63) sha_compress();
    endfunction

    // Absorb one transaction; return 1 with the digest when it ends a message.
    function automatic bit sha1_absorb_item(input t_in_item it, output bit [159:0] digest);
        bit [5:0]  pos;
        bit [63:0] bits;
        digest = '0;
        if (it.byte_present) begin
            sha_put_byte(sha_len[5:0], it.msg_byte);
            sha_len = sha_len + 61'd1;
        end
        if (!it.end_of_message) return 1'b0;
        pos = sha_len[5:0];
        sha_put_byte(pos, 8'h80);
        pos = pos + 6'd1;
        while (pos != 6'd56) begin
            sha_put_byte(pos, 8'h00);
            pos = pos + 6'd1;
        end
        bits = {sha_len, 3'b000};
        sha_block[14] = bits[63:32];
        sha_block[15] = bits[31:0];
        sha_compress();
        digest = {sha_chain[0], sha_chain[1], sha_chain[2], sha_chain[3], sha_chain[4]};
        sha_restart();
        return 1'b1;
    endfunction

    // Offer one transaction after a random gap, wait for the handshake,
    // then queue the digest words that it releases.
    task automatic send_item(input t_in_item it, input bit known, input bit [159:0] known_digest);
        int         gap;
        bit [159:0] digest;
        t_out_item  w;
        gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        if (sha1_absorb_item(it, digest)) begin
            if (known) digest = known_digest;
            for (int i = 0; i < 5; i++) begin
                w.digest_word = digest[159 - 32*i -: 32];
                w.word_index  = i[IDX_W-1:0];
                w.last_word   = (i[IDX_W-1:0] == LAST_IDX);
                pending_words.push_back(w);
            end
        end
    endtask

    // Hold the sender until every queued digest word has been taken.
    task automatic drain_digest();
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
    endtask

    // One well-formed message of len bytes with random content and idle noise.
    task automatic send_message(input int len);
        bit       carry_last;
        int       plain;
        t_in_item it;
        carry_last = (len != 0) && ($urandom_range(0, 1) == 1);
        plain = carry_last ? len - 1 : len;
        for (int i = 0; i < plain; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                it = '{msg_byte: 8'($urandom), byte_present: 1'b0, end_of_message: 1'b0};
                send_item(it, 1'b0, NO_DIGEST);
            end
            it = '{msg_byte: 8'($urandom), byte_present: 1'b1, end_of_message: 1'b0};
            send_item(it, 1'b0, NO_DIGEST);
            random_items++;
        end
        it = '{msg_byte: 8'($urandom), byte_present: carry_last, end_of_message: 1'b1};
        send_item(it, 1'b0, NO_DIGEST);
        random_items++;
        random_msgs++;
    endtask

    // Output side: check each taken digest word, then stall a random while.
    always @(posedge clk) begin : digest_monitor
        t_out_item exp;
        int        n;
        n = stall_left;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected digest word: word %h index %0d last %0b",
                             out_data.digest_word, out_data.word_index, out_data.last_word);
            end else begin
                exp = pending_words.pop_front();
                if (out_data.digest_word !== exp.digest_word ||
                    out_data.word_index !== exp.word_index ||
                    out_data.last_word !== exp.last_word) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                                 exp.digest_word, exp.word_index, exp.last_word,
                                 out_data.digest_word, out_data.word_index,
                                 out_data.last_word);
                end
            end
            n = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        end else if (n != 0) begin
            n = n - 1;
        end
        stall_left <= n;
        out_stall  <= (n != 0);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int len;
        sha_restart();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(DIRECTED[i].item, DIRECTED[i].known, DIRECTED[i].digest);
        drain_digest();

        // Open with a length that forces the extra padding block.
        len = $urandom_range(56, 63);
        while (random_items < RANDOM_ITEMS || random_msgs < RANDOM_MSGS) begin
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
            send_message(len);
            if ($urandom_range(0, 4) == 0) drain_digest();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
        end

        drain_digest();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
